// File: rtl/mlpq_pkg.sv
// Shared types and codes for the multi-level priority FIFO.
// No dependencies; imported by the interfaces and by mlpq_ctrl, mlpq_dp and the core.
`default_nettype none

package mlpq_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_DATA_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_INVALID  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_TOP_LEVEL      = 1'b0;
  localparam cfg_index_t CFG_LEVEL_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_issue;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/mlpq_ifs.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on mlpq_pkg.
`default_nettype none

interface mlpq_in_if;
  import mlpq_pkg::*;
  logic               valid;
  logic               ready;
  op_t                op;
  logic [1:0]         level;
  logic signed [31:0] data;

  modport source (output valid, op, level, data, input ready);
  modport sink   (input valid, op, level, data, output ready);
endinterface

interface mlpq_out_if;
  import mlpq_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic               head_valid;
  logic signed [31:0] head_data;
  logic [1:0]         head_level;
  logic [3:0]         nonempty_mask;

  modport source (output valid, status, head_valid, head_data, head_level, nonempty_mask,
                  input ready);
  modport sink   (input valid, status, head_valid, head_data, head_level, nonempty_mask,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/mlpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mlpq_ctrl.sv
// Sequencer: capture, state update, head read, result load.
// Depends on mlpq_pkg.
`default_nettype none

module mlpq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                out_ready,
  input  wire mlpq_pkg::dp_stat_t  stat,
  output mlpq_pkg::dp_cmd_t        cmd
);
  import mlpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        // wait for the output register to free up
        if (!stat.out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mlpq_dp.sv
// Datapath: config registers, per-level counts and pointers, entry RAM,
// head search and result register. Depends on mlpq_pkg and mlpq_ram.
`default_nettype none

module mlpq_dp #(
  parameter int LEVELS = 4,
  parameter int DEPTH  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire mlpq_pkg::cfg_index_t                cfg_index,
  input  wire logic [mlpq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire mlpq_pkg::op_t                       in_op,
  input  wire logic [1:0]                          in_level,
  input  wire logic signed [mlpq_pkg::DATA_W-1:0]  in_data,
  input  wire mlpq_pkg::dp_cmd_t                   cmd,
  output mlpq_pkg::dp_stat_t                       stat,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output mlpq_pkg::status_t                        out_status,
  output logic                                     out_head_valid,
  output logic signed [mlpq_pkg::DATA_W-1:0]       out_head_data,
  output logic [1:0]                               out_head_level,
  output logic [3:0]                               out_nonempty_mask
);
  import mlpq_pkg::*;

  localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CAPW = (CW > 5) ? CW : 5;
  localparam int RD   = LEVELS * DEPTH;
  localparam int AW   = (RD > 1) ? $clog2(RD) : 1;

  // configuration
  logic [1:0] top_level_r;
  logic [4:0] capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_level_r <= 2'd3;
      capacity_r  <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOP_LEVEL:      top_level_r <= cfg_data[1:0];
        CFG_LEVEL_CAPACITY: capacity_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [1:0]      eff_top;
  logic [CAPW-1:0] eff_cap;

  always_comb begin
    eff_top = (int'(top_level_r) >= LEVELS) ? 2'(LEVELS - 1) : top_level_r;
    eff_cap = (CAPW'(capacity_r) > CAPW'(DEPTH)) ? CAPW'(DEPTH) : CAPW'(capacity_r);
  end

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [CAPW-1:0] cap);
    logic [CAPW-1:0] n;
    n = CAPW'(p) + CAPW'(1);
    if (n >= cap || n >= CAPW'(DEPTH)) begin
      return '0;
    end
    return PW'(n);
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] l,
                                              input logic [PW-1:0] p);
    return AW'(int'(l) * DEPTH + int'(p));
  endfunction

  // captured request
  op_t                op_r;
  logic [1:0]         lvl_r;
  logic [DATA_W-1:0]  data_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      lvl_r  <= in_level;
      data_r <= in_data;
    end
  end

  // per-level state
  logic [CW-1:0] count_r [LEVELS];
  logic [CW-1:0] count_nxt [LEVELS];
  logic [PW-1:0] rp_r [LEVELS];
  logic [PW-1:0] rp_nxt [LEVELS];
  logic [PW-1:0] wp_r [LEVELS];
  logic [PW-1:0] wp_nxt [LEVELS];

  // highest non-empty level within the active range
  logic [LEVELS-1:0] nonempty;
  logic              head_found;
  logic [LW-1:0]     head_idx;

  always_comb begin
    head_found = 1'b0;
    head_idx   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (count_r[i] != '0);
      if (i <= int'(eff_top) && nonempty[i]) begin
        head_found = 1'b1;
        head_idx   = LW'(i);
      end
    end
  end

  logic          lvl_ok;
  logic [LW-1:0] ins_idx;
  logic          ins_full;
  logic          do_write;
  status_t       status_nxt;

  always_comb begin
    lvl_ok   = (lvl_r <= eff_top) && (int'(lvl_r) < LEVELS);
    ins_idx  = LW'(lvl_r);
    ins_full = (CAPW'(count_r[ins_idx]) >= eff_cap);
    do_write = cmd.exec && (op_r == OP_INSERT) && lvl_ok && !ins_full;

    status_nxt = ST_OK;
    if (op_r == OP_INSERT) begin
      if (!lvl_ok) begin
        status_nxt = ST_INVALID;
      end else if (ins_full) begin
        status_nxt = ST_OVERFLOW;
      end
    end else if (!head_found) begin
      status_nxt = ST_EMPTY;
    end

    for (int i = 0; i < LEVELS; i++) begin
      count_nxt[i] = count_r[i];
      rp_nxt[i]    = rp_r[i];
      wp_nxt[i]    = wp_r[i];
      if (cmd.exec) begin
        if (op_r == OP_INSERT) begin
          if (do_write && ins_idx == LW'(i)) begin
            count_nxt[i] = count_r[i] + CW'(1);
            wp_nxt[i]    = advance(wp_r[i], eff_cap);
          end
        end else if (head_found && head_idx == LW'(i)) begin
          count_nxt[i] = count_r[i] - CW'(1);
          if (count_r[i] == CW'(1)) begin
            // level drained: pointers restart at slot zero
            rp_nxt[i] = '0;
            wp_nxt[i] = '0;
          end else begin
            rp_nxt[i] = advance(rp_r[i], eff_cap);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        count_r[i] <= '0;
        rp_r[i]    <= '0;
        wp_r[i]    <= '0;
      end
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        count_r[i] <= count_nxt[i];
        rp_r[i]    <= rp_nxt[i];
        wp_r[i]    <= wp_nxt[i];
      end
    end
  end

  status_t status_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  // head read runs in the cycle after the update so it sees the new pointers
  logic              hd_found_r;
  logic [LW-1:0]     hd_idx_r;
  logic [DATA_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      hd_found_r <= head_found;
      hd_idx_r   <= head_idx;
    end
  end

  mlpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RD)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (slot_addr(ins_idx, wp_r[ins_idx])),
    .wdata (data_r),
    .re    (cmd.rd_issue),
    .raddr (slot_addr(head_idx, rp_r[head_idx])),
    .rdata (rdata)
  );

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status        <= status_r;
      out_head_valid    <= hd_found_r;
      out_head_data     <= hd_found_r ? rdata : '0;
      out_head_level    <= hd_found_r ? 2'(hd_idx_r) : 2'd0;
      out_nonempty_mask <= 4'(nonempty);
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/multi_level_priority_fifo_core.sv
// Multi-level priority FIFO: one circular FIFO per level in a shared RAM.
// Steps after the input transfer: state update, registered RAM read of the new
// head, result load. A new request is accepted only after the previous one has been
// loaded into the result register; the load waits while an earlier result is not taken.
// Reset clears config to top_level 3 / capacity 16, all counts and pointers;
// the entry RAM is not cleared and needs no init time.
`default_nettype none

module multi_level_priority_fifo_core #(
  parameter int LEVELS = 4,
  parameter int DEPTH  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mlpq_in_if.sink                              in_ch,
  mlpq_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire mlpq_pkg::cfg_index_t            cfg_index,
  input  wire logic [mlpq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mlpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlpq_dp #(
    .LEVELS (LEVELS),
    .DEPTH  (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_ch.op),
    .in_level          (in_ch.level),
    .in_data           (in_ch.data),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_head_valid    (out_ch.head_valid),
    .out_head_data     (out_ch.head_data),
    .out_head_level    (out_ch.head_level),
    .out_nonempty_mask (out_ch.nonempty_mask)
  );

endmodule

`default_nettype wire
